FILE: rtl/core/glos_pkg.sv
// ----------------------------------------------------------------------------
// glos_pkg: shared types and codes for the grid line-of-sight block
//
// Holds the transaction mode codes, the unit step codes and the status
// struct that the line walker hands to the sequencer.
// ----------------------------------------------------------------------------
package glos_pkg;

  // Transaction modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Two's complement unit step codes
  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  // Walker status towards the sequencer
  typedef struct packed {
    logic       arrive;   // next position is the end cell
    logic [1:0] step_x;   // x part of the next unit step
    logic [1:0] step_y;   // y part of the next unit step
  } walk_sts_t;

endpackage

FILE: rtl/core/glos_map.sv
// ----------------------------------------------------------------------------
// glos_map: open-cell bitmap
//
// One bit per grid cell, one write and one registered read port. After
// reset a sweep clears every cell to blocked, one cell per cycle, and
// init_done_o rises when the sweep is finished.
// ----------------------------------------------------------------------------
module glos_map import glos_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [2*COORD_BITS-1:0] waddr_i,
  input  logic                    wdata_i,
  input  logic [2*COORD_BITS-1:0] raddr_i,
  output logic                    rdata_o,
  output logic                    init_done_o
);

  localparam int unsigned AddrBits = 2 * COORD_BITS;
  localparam int unsigned Cells    = 1 << AddrBits;

  logic                mem_q [Cells];
  logic [AddrBits-1:0] sweep_q;
  logic                sweep_done_q;
  logic                rdata_q;

  // Advance the clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= '0;
      sweep_done_q <= 1'b0;
    end else if (!sweep_done_q) begin
      sweep_q <= sweep_q + 1'b1;
      if (sweep_q == {AddrBits{1'b1}}) begin
        sweep_done_q <= 1'b1;
      end
    end
  end

  // Write port (sweep has priority) and registered read port
  always_ff @(posedge clk_i) begin
    if (!sweep_done_q) begin
      mem_q[sweep_q] <= 1'b0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o     = rdata_q;
  assign init_done_o = sweep_done_q;

endmodule

FILE: rtl/core/glos_walk.sv
// ----------------------------------------------------------------------------
// glos_walk: Bresenham line stepper
//
// Holds the current position and error term of one line and takes one unit
// step per cycle on request. The next position is presented ahead of the
// step so that the bitmap read can be issued in the same cycle.
// ----------------------------------------------------------------------------
module glos_walk import glos_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         step_i,
  input  logic signed [COORD_BITS-1:0] from_x_i,
  input  logic signed [COORD_BITS-1:0] from_y_i,
  input  logic signed [COORD_BITS-1:0] to_x_i,
  input  logic signed [COORD_BITS-1:0] to_y_i,
  output logic signed [COORD_BITS-1:0] nxt_x_o,
  output logic signed [COORD_BITS-1:0] nxt_y_o,
  output walk_sts_t                    sts_o
);

  // Error term width: covers dx + dy and the running error with margin
  localparam int unsigned ErrBits = COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] x_q, y_q, end_x_q, end_y_q;
  logic signed [ErrBits-1:0]    err_q, dx_q, dy_q;
  logic                         sx_neg_q, sy_neg_q;

  logic signed [ErrBits-1:0]    diff_x, diff_y, abs_x, abs_y, err_d;
  logic signed [ErrBits:0]      e2;
  logic                         move_x, move_y;
  logic signed [COORD_BITS-1:0] nxt_x, nxt_y;

  // Set up deltas from the endpoints
  always_comb begin
    diff_x = ErrBits'(to_x_i) - ErrBits'(from_x_i);
    diff_y = ErrBits'(to_y_i) - ErrBits'(from_y_i);
    abs_x  = diff_x[ErrBits-1] ? -diff_x : diff_x;
    abs_y  = diff_y[ErrBits-1] ? -diff_y : diff_y;
  end

  // One Bresenham step
  always_comb begin
    e2     = {err_q, 1'b0};
    move_x = e2 >= (ErrBits+1)'(dy_q);
    move_y = e2 <= (ErrBits+1)'(dx_q);
    err_d  = err_q;
    nxt_x  = x_q;
    nxt_y  = y_q;
    if (move_x) begin
      err_d = err_d + dy_q;
      nxt_x = sx_neg_q ? x_q - 1'b1 : x_q + 1'b1;
    end
    if (move_y) begin
      err_d = err_d + dx_q;
      nxt_y = sy_neg_q ? y_q - 1'b1 : y_q + 1'b1;
    end
  end

  // Hold the line state; load on a new query, advance on request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      end_x_q  <= '0;
      end_y_q  <= '0;
      err_q    <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      sx_neg_q <= 1'b0;
      sy_neg_q <= 1'b0;
    end else if (load_i) begin
      x_q      <= from_x_i;
      y_q      <= from_y_i;
      end_x_q  <= to_x_i;
      end_y_q  <= to_y_i;
      dx_q     <= abs_x;
      dy_q     <= -abs_y;
      err_q    <= abs_x - abs_y;
      sx_neg_q <= !(from_x_i < to_x_i);
      sy_neg_q <= !(from_y_i < to_y_i);
    end else if (step_i) begin
      x_q   <= nxt_x;
      y_q   <= nxt_y;
      err_q <= err_d;
    end
  end

  assign nxt_x_o       = nxt_x;
  assign nxt_y_o       = nxt_y;
  assign sts_o.arrive  = (nxt_x == end_x_q) && (nxt_y == end_y_q);
  assign sts_o.step_x  = !move_x ? STEP_ZERO : (sx_neg_q ? STEP_NEG : STEP_POS);
  assign sts_o.step_y  = !move_y ? STEP_ZERO : (sy_neg_q ? STEP_NEG : STEP_POS);

endmodule

FILE: rtl/core/grid_line_of_sight.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight: line-of-sight test over a bitmap of open cells
//
// A transaction is taken when start is high and busy is low; its single
// result is marked on the result ports by done_o, high for a single cycle,
// and the receiver cannot stall it. A write transaction updates one cell in
// the cycle it is taken and reports in the next cycle. A query with equal
// endpoints also reports in the next cycle; any other query walks the line
// one Bresenham step per cycle through the stepper and the bitmap read
// port, and reports when the next position is the end cell, or earlier
// when a blocked cell ends the walk. After reset busy stays high while
// every cell is cleared to blocked.
// ----------------------------------------------------------------------------
module grid_line_of_sight import glos_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode_i,
  input  logic signed [COORD_BITS-1:0] cell_x_i,
  input  logic signed [COORD_BITS-1:0] cell_y_i,
  input  logic                         cell_open_i,
  input  logic signed [COORD_BITS-1:0] from_x_i,
  input  logic signed [COORD_BITS-1:0] from_y_i,
  input  logic signed [COORD_BITS-1:0] to_x_i,
  input  logic signed [COORD_BITS-1:0] to_y_i,
  output logic                         done_o,
  output logic                         clear_o,
  output logic signed [1:0]            last_step_x_o,
  output logic signed [1:0]            last_step_y_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e    state_q;
  logic      pend_q;
  logic      done_q, clear_q;
  logic [1:0] step_x_q, step_y_q;

  logic      accept, map_we, walk_load, walk_step;
  logic      map_rdata, map_ready;
  logic      ends_equal;
  walk_sts_t walk_sts;
  logic signed [COORD_BITS-1:0] nxt_x, nxt_y;

  assign accept     = start && (state_q == ST_IDLE);
  assign map_we     = accept && (mode_i == MODE_WRITE);
  assign ends_equal = (from_x_i == to_x_i) && (from_y_i == to_y_i);
  assign walk_load  = accept && (mode_i == MODE_QUERY);
  // Step while the current cell is known open or not yet checked, until the end cell is next
  assign walk_step  = (state_q == ST_WALK) && !(pend_q && !map_rdata) && !walk_sts.arrive;

  glos_map #(
    .COORD_BITS (COORD_BITS)
  ) u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (map_we),
    .waddr_i     ({cell_y_i, cell_x_i}),
    .wdata_i     (cell_open_i),
    .raddr_i     ({nxt_y, nxt_x}),
    .rdata_o     (map_rdata),
    .init_done_o (map_ready)
  );

  glos_walk #(
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (walk_load),
    .step_i   (walk_step),
    .from_x_i (from_x_i),
    .from_y_i (from_y_i),
    .to_x_i   (to_x_i),
    .to_y_i   (to_y_i),
    .nxt_x_o  (nxt_x),
    .nxt_y_o  (nxt_y),
    .sts_o    (walk_sts)
  );

  // Sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      clear_q  <= 1'b0;
      step_x_q <= STEP_ZERO;
      step_y_q <= STEP_ZERO;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          if (map_ready) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            step_x_q <= STEP_ZERO;
            step_y_q <= STEP_ZERO;
            pend_q   <= 1'b0;
            if (mode_i == MODE_WRITE) begin
              done_q  <= 1'b1;
              clear_q <= 1'b0;
            end else if (ends_equal) begin
              done_q  <= 1'b1;
              clear_q <= 1'b1;
            end else begin
              state_q <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (pend_q && !map_rdata) begin
            // Drop the query on a blocked cell
            done_q   <= 1'b1;
            clear_q  <= 1'b0;
            step_x_q <= STEP_ZERO;
            step_y_q <= STEP_ZERO;
            state_q  <= ST_IDLE;
          end else if (walk_sts.arrive) begin
            done_q   <= 1'b1;
            clear_q  <= 1'b1;
            step_x_q <= walk_sts.step_x;
            step_y_q <= walk_sts.step_y;
            state_q  <= ST_IDLE;
          end else begin
            pend_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign clear_o       = clear_q;
  assign last_step_x_o = step_x_q;
  assign last_step_y_o = step_y_q;

endmodule

FILE: tb/sv/tb_grid_line_of_sight.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_line_of_sight: self-checking testbench for the line-of-sight block
//
// Drives write and query transactions through the start/busy handshake and
// predicts every result with a local copy of the cell bitmap and its own
// Bresenham walker. Directed tests cover the grid corners, adjacent and
// equal endpoints, unwritten cells and blocked lines. The random part mostly
// opens corridors along a line and then queries it, mixed with noise.
// ----------------------------------------------------------------------------
module tb_grid_line_of_sight;
  import glos_pkg::*;

  localparam int CB          = 6;
  localparam int CELL_BITS   = 2 * CB;
  localparam int NUM_CELLS   = 1 << CELL_BITS;
  localparam int RANDOM_ITEMS = 1150;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = (1 << CB) + 8;

  typedef struct {
    logic          mode;
    logic [CB-1:0] cell_x;
    logic [CB-1:0] cell_y;
    logic          cell_open;
    logic [CB-1:0] from_x;
    logic [CB-1:0] from_y;
    logic [CB-1:0] to_x;
    logic [CB-1:0] to_y;
  } los_item_t;

  typedef struct packed {
    logic       clear;
    logic [1:0] last_step_x;
    logic [1:0] last_step_y;
  } los_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 mode_i;
  logic signed [CB-1:0] cell_x_i;
  logic signed [CB-1:0] cell_y_i;
  logic                 cell_open_i;
  logic signed [CB-1:0] from_x_i;
  logic signed [CB-1:0] from_y_i;
  logic signed [CB-1:0] to_x_i;
  logic signed [CB-1:0] to_y_i;
  logic                 done_o;
  logic                 clear_o;
  logic signed [1:0]    last_step_x_o;
  logic signed [1:0]    last_step_y_o;

  // Local copy of the bitmap, results still owed by the block
  bit                   open_cells [NUM_CELLS];
  logic [CELL_BITS-1:0] line_cells[$];
  los_result_t          pending_results[$];
  int                   fail_count = 0;
  int                   item_count = 0;
  int                   stall_cycles = 0;
  bit                   no_gap = 1'b0;

  grid_line_of_sight #(
    .COORD_BITS(CB)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_open_i  (cell_open_i),
    .from_x_i     (from_x_i),
    .from_y_i     (from_y_i),
    .to_x_i       (to_x_i),
    .to_y_i       (to_y_i),
    .done_o       (done_o),
    .clear_o      (clear_o),
    .last_step_x_o(last_step_x_o),
    .last_step_y_o(last_step_y_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int coord_int(logic [CB-1:0] v);
    return int'($signed(v));
  endfunction

  // Walk the Bresenham line, record every intermediate cell and work out
  // the result against the local bitmap
  function automatic los_result_t walk_line(int x0, int y0, int x1, int y1);
    los_result_t          res;
    int                   dx, dy, sx, sy, err, e2, px, py;
    bit                   blocked;
    logic [CELL_BITS-1:0] idx;
    res = '0;
    blocked = 1'b0;
    line_cells.delete();
    if (x0 == x1 && y0 == y1) begin
      res.clear = 1'b1;
      return res;
    end
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    while (x0 != x1 || y0 != y1) begin
      px = x0;
      py = y0;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0  += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0  += sy;
      end
      if (x0 == x1 && y0 == y1) begin
        if (!blocked) begin
          res.clear       = 1'b1;
          res.last_step_x = 2'(x0 - px);
          res.last_step_y = 2'(y0 - py);
        end
      end else begin
        idx = {CB'(y0), CB'(x0)};
        line_cells = {line_cells, idx};
        if (!open_cells[idx]) blocked = 1'b1;
      end
    end
    return res;
  endfunction

  // Apply one accepted transaction to the local state
  function automatic los_result_t predict_item(los_item_t item);
    if (item.mode == MODE_WRITE) begin
      open_cells[{item.cell_y, item.cell_x}] = item.cell_open;
      return '0;
    end
    return walk_line(coord_int(item.from_x), coord_int(item.from_y),
                     coord_int(item.to_x), coord_int(item.to_y));
  endfunction

  function automatic los_item_t make_write(int x, int y, bit open_bit);
    los_item_t item;
    item.mode      = MODE_WRITE;
    item.cell_x    = CB'(x);
    item.cell_y    = CB'(y);
    item.cell_open = open_bit;
    item.from_x    = CB'($urandom);
    item.from_y    = CB'($urandom);
    item.to_x      = CB'($urandom);
    item.to_y      = CB'($urandom);
    return item;
  endfunction

  function automatic los_item_t make_query(int x0, int y0, int x1, int y1);
    los_item_t item;
    item.mode      = MODE_QUERY;
    item.cell_x    = CB'($urandom);
    item.cell_y    = CB'($urandom);
    item.cell_open = 1'($urandom);
    item.from_x    = CB'(x0);
    item.from_y    = CB'(y0);
    item.to_x      = CB'(x1);
    item.to_y      = CB'(y1);
    return item;
  endfunction

  // Send one transaction after a random gap and log its expected result
  task automatic send_item(los_item_t item);
    int          gap;
    los_result_t expected;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i      <= item.mode;
    cell_x_i    <= item.cell_x;
    cell_y_i    <= item.cell_y;
    cell_open_i <= item.cell_open;
    from_x_i    <= item.from_x;
    from_y_i    <= item.from_y;
    to_x_i      <= item.to_x;
    to_y_i      <= item.to_y;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected = predict_item(item);
    pending_results = {pending_results, expected};
    item_count++;
  endtask

  // Hold the sender until the block has reported everything
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Open cells along a line, blocking a few, then query it or a variant
  task automatic run_corridor(int fx, int fy, int tx, int ty);
    logic [CELL_BITS-1:0] cells[$];
    int                   k;
    int                   pick;
    void'(walk_line(fx, fy, tx, ty));
    cells = line_cells;
    for (k = 0; k < cells.size(); k++) begin
      send_item(make_write(coord_int(cells[k][CB-1:0]), coord_int(cells[k][CELL_BITS-1:CB]),
                           $urandom_range(0, 99) < 94));
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) send_item(make_query(fx, fy, tx, ty));
    else if (pick < 9) send_item(make_query(tx, ty, fx, fy));
    else send_item(make_query(fx, fy, tx + $urandom_range(0, 2) - 1, ty));
  endtask

  function automatic int clamp_coord(int v);
    if (v < -(1 << (CB - 1))) return -(1 << (CB - 1));
    if (v > (1 << (CB - 1)) - 1) return (1 << (CB - 1)) - 1;
    return v;
  endfunction

  // Queries against the freshly cleared bitmap
  task automatic test_reset_state();
    send_item(make_query(0, 0, 0, 0));
    send_item(make_query(-32, -32, -32, -32));
    send_item(make_query(-32, -32, 31, 31));
    send_item(make_query(31, -32, -32, 31));
    send_item(make_query(5, 5, 6, 6));
    send_item(make_query(31, -32, 30, -31));
    send_item(make_query(-32, 0, -31, 0));
  endtask

  // Writes at the grid edges, clear and blocked lines through them
  task automatic test_cell_writes();
    send_item(make_write(0, 1, 1'b1));
    send_item(make_write(0, 2, 1'b1));
    send_item(make_query(0, 0, 0, 3));
    send_item(make_write(0, 2, 1'b0));
    send_item(make_query(0, 0, 0, 3));
    send_item(make_write(-32, -31, 1'b1));
    send_item(make_query(-32, -32, -32, -30));
    send_item(make_write(30, 31, 1'b1));
    send_item(make_query(29, 31, 31, 31));
    send_item(make_query(31, 31, 29, 31));
    send_item(make_write(-31, 30, 1'b1));
    send_item(make_query(-30, 29, -32, 31));
    send_item(make_write(31, -32, 1'b1));
    send_item(make_query(31, -31, 31, -32));
  endtask

  // Let every result drain before carrying on
  task automatic test_drain_pause();
    wait_for_results();
    send_item(make_query(31, 31, -32, -32));
    send_item(make_write(-32, -32, 1'b1));
  endtask

  // Mostly corridors with random content, the rest random noise
  task automatic test_random_mix();
    int kind, fx, fy, tx, ty;
    while (item_count < RANDOM_ITEMS) begin
      no_gap = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      fx = $urandom_range(0, 63) - 32;
      fy = $urandom_range(0, 63) - 32;
      if (kind < 55) begin
        tx = clamp_coord(fx + $urandom_range(0, 14) - 7);
        ty = clamp_coord(fy + $urandom_range(0, 14) - 7);
        run_corridor(fx, fy, tx, ty);
      end else if (kind < 59) begin
        run_corridor(fx, fy, $urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32);
      end else if (kind < 80) begin
        send_item(make_write(fx, fy, 1'($urandom)));
      end else begin
        send_item(make_query(fx, fy, $urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32));
      end
    end
    no_gap = 1'b0;
  endtask

  // Compare each reported result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    los_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (clear_o !== want.clear) begin
          $error("clear: expected %0d, got %0d", want.clear, clear_o);
          fail_count++;
        end
        if (last_step_x_o !== want.last_step_x) begin
          $error("last_step_x: expected %0d, got %0d",
                 $signed(want.last_step_x), last_step_x_o);
          fail_count++;
        end
        if (last_step_y_o !== want.last_step_y) begin
          $error("last_step_y: expected %0d, got %0d",
                 $signed(want.last_step_y), last_step_y_o);
          fail_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    mode_i      = MODE_WRITE;
    cell_x_i    = '0;
    cell_y_i    = '0;
    cell_open_i = 1'b0;
    from_x_i    = '0;
    from_y_i    = '0;
    to_x_i      = '0;
    to_y_i      = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_cell_writes();
    test_drain_pause();
    test_random_mix();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
